[design/urbs_pkg.sv]
// ----------------------------------------------------------------------------
// urbs_pkg
// Shared constants, types and control structs of the retry back-off selector.
// ----------------------------------------------------------------------------
package urbs_pkg;

    localparam int MAX_SERVERS = 8;
    localparam int IDX_W       = 3;
    localparam int CNT_W       = 4;
    localparam int MODE_W      = 2;
    localparam int CREDIT_W    = 17;
    localparam int BACKOFF_W   = 16;

    localparam logic [CNT_W-1:0]     SERVER_COUNT_RESET = CNT_W'(1);
    localparam logic [CNT_W-1:0]     MAX_COUNT          = CNT_W'(MAX_SERVERS);
    localparam logic [CREDIT_W-1:0]  CREDIT_RESET       = CREDIT_W'(2);
    localparam logic [CREDIT_W-1:0]  CREDIT_ONE         = CREDIT_W'(1);
    localparam logic [CREDIT_W-1:0]  CREDIT_MIN         = {1'b1, {(CREDIT_W-1){1'b0}}};
    localparam logic [BACKOFF_W-1:0] BACKOFF_RESET      = BACKOFF_W'(1);
    localparam logic [BACKOFF_W-1:0] BACKOFF_MAX        = {BACKOFF_W{1'b1}};

    typedef enum logic [MODE_W-1:0] {
        MODE_PICK    = 2'd0,
        MODE_FAIL    = 2'd1,
        MODE_SUCCESS = 2'd2,
        MODE_NONE    = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INC,
        ST_SCAN,
        ST_FORCE,
        ST_FAIL,
        ST_REPORT
    } state_t;

    typedef struct packed {
        logic capture;
        logic inc_all;
        logic scan_step;
        logic pick_found;
        logic pick_force;
        logic fail_upd;
        logic report;
    } cmd_t;

    typedef struct packed {
        logic cfg_zero;
        logic scan_hit;
        logic scan_last;
        logic out_free;
    } status_t;

endpackage

[design/urbs_req_if.sv]
// ----------------------------------------------------------------------------
// urbs_req_if
// Request channel: mode and server index with valid/ready.
// ----------------------------------------------------------------------------
interface urbs_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] mode;
    logic [2:0] server_index;

    modport source (output valid, output mode, output server_index, input ready);
    modport sink   (input valid, input mode, input server_index, output ready);
endinterface

[design/urbs_rsp_if.sv]
// ----------------------------------------------------------------------------
// urbs_rsp_if
// Result channel: chosen server and pick flags with valid/ready.
// ----------------------------------------------------------------------------
interface urbs_rsp_if;
    logic       valid;
    logic       ready;
    logic [2:0] chosen_server;
    logic       found;
    logic       by_least_backoff;

    modport source (output valid, output chosen_server, output found,
                    output by_least_backoff, input ready);
    modport sink   (input valid, input chosen_server, input found,
                    input by_least_backoff, output ready);
endinterface

[design/upstream_retry_backoff_selector.sv]
// ----------------------------------------------------------------------------
// upstream_retry_backoff_selector
// Picks an upstream server by round-robin retry credit, falls back to the
// least back-off server, and tracks failure and success reports.
// A pick scans the servers one per cycle from the pointer and loads the first
// credited server, or after a full scan the least back-off server; a report
// or an empty pick loads its result without a scan. A new request is taken
// the cycle after a result loads.
// Reset: credits 2, back-offs 1, pointer 0, server count 1, output empty.
// ----------------------------------------------------------------------------
module upstream_retry_backoff_selector (
    input  logic       clk,
    input  logic       rst_n,
    urbs_req_if.sink   req,
    urbs_rsp_if.source rsp,
    input  logic       cfg_we,
    input  logic [3:0] cfg_wdata
);
    import urbs_pkg::*;

    cmd_t    cmd;
    status_t st;

    urbs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_mode  (req.mode),
        .in_ready (req.ready),
        .st       (st),
        .cmd      (cmd)
    );

    urbs_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .in_mode    (req.mode),
        .in_index   (req.server_index),
        .cmd        (cmd),
        .st         (st),
        .out_valid  (rsp.valid),
        .out_ready  (rsp.ready),
        .out_server (rsp.chosen_server),
        .out_found  (rsp.found),
        .out_least  (rsp.by_least_backoff)
    );

endmodule

[design/urbs_ctrl.sv]
// ----------------------------------------------------------------------------
// urbs_ctrl
// Sequencer: accepts a request, steps the datapath through the credit
// refresh, round-robin scan, forced pick or report update.
// ----------------------------------------------------------------------------
module urbs_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [1:0]        in_mode,
    output logic              in_ready,
    input  urbs_pkg::status_t st,
    output urbs_pkg::cmd_t    cmd
);
    import urbs_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    case (mode_t'(in_mode))
                        MODE_PICK: state_next = st.cfg_zero ? ST_REPORT : ST_INC;
                        MODE_FAIL: state_next = ST_FAIL;
                        default:   state_next = ST_REPORT;
                    endcase
                end
            end
            ST_INC:
            begin
                cmd.inc_all = 1'b1;
                state_next  = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (st.scan_hit)
                begin
                    if (st.out_free)
                    begin
                        cmd.pick_found = 1'b1;
                        state_next     = ST_IDLE;
                    end
                end
                else
                begin
                    cmd.scan_step = 1'b1;
                    if (st.scan_last)
                    begin
                        state_next = ST_FORCE;
                    end
                end
            end
            ST_FORCE:
            begin
                if (st.out_free)
                begin
                    cmd.pick_force = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            ST_FAIL:
            begin
                if (st.out_free)
                begin
                    cmd.fail_upd = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_REPORT:
            begin
                if (st.out_free)
                begin
                    cmd.report = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    a_one_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.pick_found, cmd.pick_force, cmd.fail_upd, cmd.report}))
        else $error("more than one result load in a cycle");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.pick_found || cmd.pick_force || cmd.fail_upd || cmd.report) |-> st.out_free)
        else $error("result load while output register is full");

    a_force_after_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FORCE) |-> ($past(state_reg) == ST_SCAN || $past(state_reg) == ST_FORCE))
        else $error("forced pick without a finished scan");

endmodule

[design/urbs_datapath.sv]
// ----------------------------------------------------------------------------
// urbs_datapath
// Per-server credit and back-off storage, scan index and least back-off
// tracker, pointer, server count register and output register.
// ----------------------------------------------------------------------------
module urbs_datapath (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [urbs_pkg::CNT_W-1:0]     cfg_wdata,
    input  logic [urbs_pkg::MODE_W-1:0]    in_mode,
    input  logic [urbs_pkg::IDX_W-1:0]     in_index,
    input  urbs_pkg::cmd_t                 cmd,
    output urbs_pkg::status_t              st,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [urbs_pkg::IDX_W-1:0]     out_server,
    output logic                           out_found,
    output logic                           out_least
);
    import urbs_pkg::*;

    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     n_reg;
    mode_t                mode_reg;
    logic [IDX_W-1:0]     idx_reg;
    logic [IDX_W-1:0]     ptr_reg;
    logic [IDX_W-1:0]     ptr_next;
    logic [IDX_W-1:0]     scan_idx_reg;
    logic [IDX_W-1:0]     scan_cnt_reg;
    logic [IDX_W-1:0]     best_idx_reg;
    logic [BACKOFF_W-1:0] best_val_reg;
    logic [CREDIT_W-1:0]  credit_reg [MAX_SERVERS];
    logic [CREDIT_W-1:0]  credit_next [MAX_SERVERS];
    logic [BACKOFF_W-1:0] backoff_reg [MAX_SERVERS];
    logic [BACKOFF_W-1:0] backoff_next [MAX_SERVERS];
    logic                 out_valid_reg;
    logic [IDX_W-1:0]     out_server_reg;
    logic                 out_found_reg;
    logic                 out_least_reg;
    logic                 out_load;
    logic [IDX_W-1:0]     res_server;
    logic                 res_found;
    logic                 res_least;

    logic [CNT_W-1:0]     n_active;
    logic [CREDIT_W-1:0]  scan_credit;
    logic [BACKOFF_W-1:0] scan_backoff;
    logic [CNT_W-1:0]     scan_idx_inc;
    logic [CNT_W-1:0]     ptr_inc;
    logic [CNT_W-1:0]     cnt_inc;
    logic                 better;
    logic [CREDIT_W-1:0]  fail_dec;
    logic [BACKOFF_W:0]   fail_dbl;
    logic [BACKOFF_W-1:0] fail_bsat;

    assign n_active     = (count_reg > MAX_COUNT) ? MAX_COUNT : count_reg;
    assign scan_credit  = credit_reg[scan_idx_reg];
    assign scan_backoff = backoff_reg[scan_idx_reg];
    assign scan_idx_inc = {1'b0, scan_idx_reg} + CNT_W'(1);
    assign ptr_inc      = {1'b0, ptr_reg} + CNT_W'(1);
    assign cnt_inc      = {1'b0, scan_cnt_reg} + CNT_W'(1);
    assign better       = (scan_backoff < best_val_reg) ||
                          ((scan_backoff == best_val_reg) && (scan_idx_reg < best_idx_reg));

    assign fail_dec  = (credit_reg[idx_reg] != CREDIT_MIN) ?
                       credit_reg[idx_reg] - CREDIT_W'(1) : credit_reg[idx_reg];
    assign fail_dbl  = {backoff_reg[idx_reg], 1'b0};
    assign fail_bsat = fail_dbl[BACKOFF_W] ? BACKOFF_MAX : fail_dbl[BACKOFF_W-1:0];

    assign st.cfg_zero  = (n_active == '0);
    assign st.scan_hit  = !scan_credit[CREDIT_W-1] && (scan_credit != '0);
    assign st.scan_last = (cnt_inc == n_reg);
    assign st.out_free  = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= SERVER_COUNT_RESET;
        end
        else if (cfg_we)
        begin
            count_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            mode_reg <= mode_t'(in_mode);
            idx_reg  <= in_index;
            n_reg    <= n_active;
        end
        if (cmd.inc_all)
        begin
            scan_idx_reg <= ({1'b0, ptr_reg} < n_reg) ? ptr_reg : '0;
            scan_cnt_reg <= '0;
            best_idx_reg <= IDX_W'(MAX_SERVERS - 1);
            best_val_reg <= BACKOFF_MAX;
        end
        else if (cmd.scan_step)
        begin
            scan_idx_reg <= (scan_idx_inc >= n_reg) ? '0 : scan_idx_inc[IDX_W-1:0];
            scan_cnt_reg <= cnt_inc[IDX_W-1:0];
            if (better)
            begin
                best_idx_reg <= scan_idx_reg;
                best_val_reg <= scan_backoff;
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < MAX_SERVERS; i++)
        begin
            credit_next[i]  = credit_reg[i];
            backoff_next[i] = backoff_reg[i];
            if (cmd.inc_all && (CNT_W'(i) < n_reg) &&
                (credit_reg[i][CREDIT_W-1] || (credit_reg[i] == '0)))
            begin
                credit_next[i] = credit_reg[i] + CREDIT_W'(1);
            end
        end
        if (cmd.pick_force)
        begin
            credit_next[best_idx_reg] = CREDIT_ONE;
            if (backoff_reg[best_idx_reg] != BACKOFF_MAX)
            begin
                backoff_next[best_idx_reg] = backoff_reg[best_idx_reg] + BACKOFF_W'(1);
            end
        end
        if (cmd.fail_upd)
        begin
            if (fail_dec == '0)
            begin
                backoff_next[idx_reg] = fail_bsat;
                credit_next[idx_reg]  = CREDIT_W'(0) - {1'b0, fail_bsat};
            end
            else
            begin
                credit_next[idx_reg] = fail_dec;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_SERVERS; i++)
            begin
                credit_reg[i]  <= CREDIT_RESET;
                backoff_reg[i] <= BACKOFF_RESET;
            end
            ptr_reg <= '0;
        end
        else
        begin
            for (int i = 0; i < MAX_SERVERS; i++)
            begin
                credit_reg[i]  <= credit_next[i];
                backoff_reg[i] <= backoff_next[i];
            end
            ptr_reg <= ptr_next;
        end
    end

    always_comb
    begin
        ptr_next   = ptr_reg;
        out_load   = 1'b0;
        res_server = '0;
        res_found  = 1'b0;
        res_least  = 1'b0;
        if (cmd.pick_found)
        begin
            out_load   = 1'b1;
            ptr_next   = scan_idx_reg;
            res_server = scan_idx_reg;
            res_found  = 1'b1;
        end
        else if (cmd.pick_force)
        begin
            out_load   = 1'b1;
            ptr_next   = best_idx_reg;
            res_server = best_idx_reg;
            res_found  = 1'b1;
            res_least  = 1'b1;
        end
        else if (cmd.fail_upd)
        begin
            out_load   = 1'b1;
            ptr_next   = (ptr_inc >= n_reg) ? '0 : ptr_inc[IDX_W-1:0];
            res_server = ptr_next;
        end
        else if (cmd.report)
        begin
            out_load = 1'b1;
            case (mode_reg)
                MODE_SUCCESS: ptr_next   = '0;
                MODE_NONE:    res_server = ptr_reg;
                default:      res_server = '0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_server_reg <= res_server;
            out_found_reg  <= res_found;
            out_least_reg  <= res_least;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_server = out_server_reg;
    assign out_found  = out_found_reg;
    assign out_least  = out_least_reg;

    a_force_credit: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pick_force |=> (credit_reg[$past(best_idx_reg)] == CREDIT_ONE))
        else $error("forced server credit not set to one");

    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.scan_step |-> ({1'b0, scan_cnt_reg} < n_reg && {1'b0, scan_idx_reg} < n_reg))
        else $error("scan ran past the server count");

    a_pick_ptr: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.pick_found || cmd.pick_force) |=> ({1'b0, ptr_reg} < n_reg))
        else $error("pointer outside active servers after a pick");

endmodule

[tb/sv/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the retry back-off selector. A directed table walks
// reset behavior, empty server count, count saturation and every request mode.
// Random phases follow: a back-off saturation run on a single server, then
// mixed traffic of every request mode at several server counts. Each result is
// compared with a table value or an in-bench predictor of the credit, back-off
// and pointer state. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_top;
    import urbs_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int PHASE_ITEMS = 85;

    typedef struct packed {
        logic [IDX_W-1:0] chosen;
        logic             found;
        logic             least;
    } selection_t;

    typedef struct {
        bit               cfg_row;
        logic [CNT_W-1:0] cfg_value;
        mode_t            mode;
        logic [IDX_W-1:0] idx;
        bit               typed;
        selection_t       want;
    } stim_row_t;

    localparam int DIRECTED_ROWS = 26;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CNT_W-1:0]     cfg_wdata;

    urbs_req_if req_bus ();
    urbs_rsp_if rsp_bus ();

    upstream_retry_backoff_selector u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_bus),
        .rsp       (rsp_bus),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    logic signed [CREDIT_W-1:0] credit_model  [MAX_SERVERS];
    logic        [BACKOFF_W-1:0] backoff_model [MAX_SERVERS];
    int                          pointer_model;
    logic        [CNT_W-1:0]     count_model;

    selection_t pending_selections [$];

    int  mismatch_count = 0;
    int  checked_count  = 0;
    int  request_count  = 0;
    int  forced_count   = 0;
    int  setting_count  = 0;
    int  quiet_cycles   = 0;
    bit  gaps_on        = 1'b1;

    stim_row_t directed_rows [DIRECTED_ROWS] = '{
        '{1'b0, 4'd0,  MODE_PICK,    3'd0, 1'b1, {3'd0, 1'b1, 1'b0}},
        '{1'b0, 4'd0,  MODE_NONE,    3'd5, 1'b1, {3'd0, 1'b0, 1'b0}},
        '{1'b0, 4'd0,  MODE_FAIL,    3'd0, 1'b1, {3'd0, 1'b0, 1'b0}},
        '{1'b0, 4'd0,  MODE_FAIL,    3'd0, 1'b1, {3'd0, 1'b0, 1'b0}},
        '{1'b0, 4'd0,  MODE_PICK,    3'd3, 1'b1, {3'd0, 1'b1, 1'b1}},
        '{1'b0, 4'd0,  MODE_SUCCESS, 3'd6, 1'b1, {3'd0, 1'b0, 1'b0}},
        '{1'b1, 4'd0,  MODE_NONE,    3'd0, 1'b0, '0},
        '{1'b0, 4'd0,  MODE_PICK,    3'd4, 1'b1, {3'd0, 1'b0, 1'b0}},
        '{1'b0, 4'd0,  MODE_FAIL,    3'd7, 1'b1, {3'd0, 1'b0, 1'b0}},
        '{1'b0, 4'd0,  MODE_NONE,    3'd2, 1'b1, {3'd0, 1'b0, 1'b0}},
        '{1'b1, 4'd15, MODE_NONE,    3'd0, 1'b0, '0},
        '{1'b0, 4'd0,  MODE_PICK,    3'd0, 1'b1, {3'd0, 1'b1, 1'b0}},
        '{1'b0, 4'd0,  MODE_FAIL,    3'd7, 1'b0, '0},
        '{1'b0, 4'd0,  MODE_PICK,    3'd0, 1'b0, '0},
        '{1'b0, 4'd0,  MODE_FAIL,    3'd1, 1'b0, '0},
        '{1'b0, 4'd0,  MODE_FAIL,    3'd1, 1'b0, '0},
        '{1'b0, 4'd0,  MODE_PICK,    3'd2, 1'b0, '0},
        '{1'b0, 4'd0,  MODE_FAIL,    3'd3, 1'b0, '0},
        '{1'b0, 4'd0,  MODE_SUCCESS, 3'd7, 1'b0, '0},
        '{1'b1, 4'd8,  MODE_NONE,    3'd0, 1'b0, '0},
        '{1'b0, 4'd0,  MODE_PICK,    3'd0, 1'b0, '0},
        '{1'b0, 4'd0,  MODE_FAIL,    3'd6, 1'b0, '0},
        '{1'b1, 4'd3,  MODE_NONE,    3'd0, 1'b0, '0},
        '{1'b0, 4'd0,  MODE_FAIL,    3'd5, 1'b0, '0},
        '{1'b0, 4'd0,  MODE_PICK,    3'd1, 1'b0, '0},
        '{1'b0, 4'd0,  MODE_NONE,    3'd0, 1'b0, '0}
    };

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int active_servers();
        return (count_model > MAX_COUNT) ? MAX_SERVERS : int'(count_model);
    endfunction

    function automatic selection_t predict_selection(input mode_t m,
                                                     input logic [IDX_W-1:0] idx);
        selection_t res;
        int         n;
        int         i;
        int         best;
        int         doubled;
        bit         hit;
        res = '0;
        hit = 1'b0;
        n   = active_servers();
        case (m)
            MODE_PICK:
            begin
                if (n != 0)
                begin
                    for (i = 0; i < n; i++)
                        if (credit_model[i] <= 0)
                            credit_model[i] = credit_model[i] + CREDIT_W'(1);
                    i = (pointer_model < n) ? pointer_model : 0;
                    for (int k = 0; k < n; k++)
                    begin
                        if (!hit && credit_model[i] > 0)
                        begin
                            hit           = 1'b1;
                            pointer_model = i;
                            res.chosen    = 3'(i);
                            res.found     = 1'b1;
                        end
                        i = (i + 1 >= n) ? 0 : i + 1;
                    end
                    if (!hit)
                    begin
                        best = 0;
                        for (i = 1; i < n; i++)
                            if (backoff_model[i] < backoff_model[best])
                                best = i;
                        if (backoff_model[best] != BACKOFF_MAX)
                            backoff_model[best] = backoff_model[best] + 1'b1;
                        credit_model[best] = CREDIT_ONE;
                        pointer_model      = best;
                        res.chosen         = 3'(best);
                        res.found          = 1'b1;
                        res.least          = 1'b1;
                    end
                end
            end
            MODE_FAIL:
            begin
                if (credit_model[idx] != $signed(CREDIT_MIN))
                    credit_model[idx] = credit_model[idx] - CREDIT_W'(1);
                if (credit_model[idx] == 0)
                begin
                    doubled = 2 * int'(backoff_model[idx]);
                    if (doubled > int'(BACKOFF_MAX))
                        doubled = int'(BACKOFF_MAX);
                    backoff_model[idx] = BACKOFF_W'(doubled);
                    credit_model[idx]  = CREDIT_W'(-doubled);
                end
                pointer_model = (pointer_model + 1 >= n) ? 0 : pointer_model + 1;
                res.chosen    = 3'(pointer_model);
            end
            MODE_SUCCESS:
            begin
                pointer_model = 0;
            end
            default:
            begin
                res.chosen = 3'(pointer_model);
            end
        endcase
        return res;
    endfunction

    function automatic int sender_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (!gaps_on || roll < 55)
            return 0;
        if (roll < 88)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    task automatic issue_request(input mode_t m, input logic [IDX_W-1:0] idx,
                                 input bit typed, input selection_t want);
        int         gap;
        selection_t predicted;
        gap = sender_gap();
        if (gap != 0)
        begin
            req_bus.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_bus.valid        = 1'b1;
        req_bus.mode         = m;
        req_bus.server_index = idx;
        @(posedge clk);
        while (!req_bus.ready)
            @(posedge clk);
        predicted = predict_selection(m, idx);
        if (predicted.least)
            forced_count++;
        pending_selections.push_back(typed ? want : predicted);
        request_count++;
        @(negedge clk);
    endtask

    task automatic write_server_count(input logic [CNT_W-1:0] value);
        req_bus.valid = 1'b0;
        while (pending_selections.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
        cfg_we    = 1'b1;
        cfg_wdata = value;
        @(negedge clk);
        cfg_we      = 1'b0;
        count_model = value;
        setting_count++;
    endtask

    task automatic random_request(input int fail_weight);
        int               roll;
        int               n;
        logic [IDX_W-1:0] idx;
        n    = active_servers();
        roll = $urandom_range(0, 99);
        idx  = 3'($urandom_range(0, 7));
        if (roll < fail_weight)
        begin
            if (n != 0 && $urandom_range(0, 3) != 0)
                idx = 3'($urandom_range(0, n - 1));
            issue_request(MODE_FAIL, idx, 1'b0, '0);
        end
        else if (roll < fail_weight + 8)
            issue_request(MODE_SUCCESS, idx, 1'b0, '0);
        else if (roll < fail_weight + 13)
            issue_request(MODE_NONE, idx, 1'b0, '0);
        else
            issue_request(MODE_PICK, idx, 1'b0, '0);
    endtask

    initial
    begin
        int          run_left;
        run_left      = 0;
        rsp_bus.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (run_left == 0)
            begin
                if (rsp_bus.ready)
                begin
                    rsp_bus.ready = 1'b0;
                    run_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                           : $urandom_range(1, 3);
                end
                else
                begin
                    rsp_bus.ready = 1'b1;
                    run_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                           : $urandom_range(1, 12);
                end
            end
            else
                run_left--;
        end
    end

    always @(posedge clk)
    begin
        selection_t head;
        if (rst_n && rsp_bus.valid && rsp_bus.ready)
        begin
            checked_count++;
            if (pending_selections.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result: server %0d found %0b least %0b",
                             rsp_bus.chosen_server, rsp_bus.found,
                             rsp_bus.by_least_backoff);
            end
            else
            begin
                head = pending_selections.pop_front();
                if (head.chosen != rsp_bus.chosen_server || head.found != rsp_bus.found ||
                    head.least != rsp_bus.by_least_backoff)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch at result %0d: expected %0d/%0b/%0b, got %0d/%0b/%0b",
                                 checked_count, head.chosen, head.found, head.least,
                                 rsp_bus.chosen_server, rsp_bus.found,
                                 rsp_bus.by_least_backoff);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("upstream_retry_backoff_selector regression: fail");
            $finish;
        end
    end

    initial
    begin
        int phase_counts [12] = '{8, 0, 15, 2, 5, 1, 8, 3, 9, 7, 4, 6};
        int fail_weight;
        rst_n                = 1'b0;
        cfg_we               = 1'b0;
        cfg_wdata            = '0;
        req_bus.valid        = 1'b0;
        req_bus.mode         = MODE_PICK;
        req_bus.server_index = '0;
        for (int i = 0; i < MAX_SERVERS; i++)
        begin
            credit_model[i]  = CREDIT_RESET;
            backoff_model[i] = BACKOFF_RESET;
        end
        pointer_model = 0;
        count_model   = SERVER_COUNT_RESET;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (directed_rows[r])
        begin
            if (directed_rows[r].cfg_row)
                write_server_count(directed_rows[r].cfg_value);
            else
                issue_request(directed_rows[r].mode, directed_rows[r].idx,
                              directed_rows[r].typed, directed_rows[r].want);
        end

        // drive server 0 to saturated back-off and floor credit
        write_server_count(4'd1);
        for (int p = 0; p < 40; p++)
        begin
            issue_request(MODE_FAIL, 3'd0, 1'b0, '0);
            issue_request(MODE_PICK, 3'($urandom_range(0, 7)), 1'b0, '0);
        end
        repeat (3) issue_request(MODE_FAIL, 3'd0, 1'b0, '0);

        foreach (phase_counts[ph])
        begin
            write_server_count(4'(phase_counts[ph]));
            gaps_on     = (ph % 4 != 3);
            fail_weight = $urandom_range(20, 70);
            repeat (PHASE_ITEMS) random_request(fail_weight);
        end
        gaps_on       = 1'b1;
        req_bus.valid = 1'b0;

        while (pending_selections.size() != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);

        $display("Ran %0d requests across %0d server-count settings (0 through 15).",
                 request_count, setting_count);
        $display("Checked %0d results; %0d picks fell back to least back-off.",
                 checked_count, forced_count);
        if (mismatch_count == 0 && pending_selections.size() == 0)
            $display("upstream_retry_backoff_selector regression: pass");
        else
            $display("upstream_retry_backoff_selector regression: fail");
        $finish;
    end
endmodule
